// File: hdl/pimit_pkg.sv
package pimit_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TIME_W = 48;

  // one arrival moving along the row of cells
  typedef struct packed {
    logic              vld;
    logic              done;
    logic              known;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] tstamp;
    logic [TIME_W-1:0] best;
  } tok_t;

endpackage

// File: hdl/pimit_cell.sv
module pimit_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pimit_pkg::tok_t   tok_i,
  output pimit_pkg::tok_t   tok_o
);

  logic                             ent_vld_r, ent_vld_nxt;
  logic [pimit_pkg::KEY_W-1:0]      ent_key_r, ent_key_nxt;
  logic [pimit_pkg::TIME_W-1:0]     ent_last_r, ent_last_nxt;
  logic [pimit_pkg::TIME_W-1:0]     ent_gap_r, ent_gap_nxt;
  pimit_pkg::tok_t                  tok_r, tok_nxt;

  logic                             hit;
  logic                             late;
  logic [pimit_pkg::TIME_W-1:0]     diff;
  logic [pimit_pkg::TIME_W-1:0]     gap;
  logic [pimit_pkg::TIME_W-1:0]     new_gap;

  assign hit     = ent_vld_r && (ent_key_r == tok_i.key);
  assign late    = tok_i.tstamp >= ent_last_r;
  assign diff    = tok_i.tstamp - ent_last_r;
  assign gap     = late ? diff : '0;
  assign new_gap = (gap < ent_gap_r) ? gap : ent_gap_r;

  always_comb begin
    ent_vld_nxt  = ent_vld_r;
    ent_key_nxt  = ent_key_r;
    ent_last_nxt = ent_last_r;
    ent_gap_nxt  = ent_gap_r;
    tok_nxt      = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (hit) begin
        // known key: lower the best gap, remember this arrival
        ent_last_nxt  = tok_i.tstamp;
        ent_gap_nxt   = new_gap;
        tok_nxt.done  = 1'b1;
        tok_nxt.known = 1'b1;
        tok_nxt.best  = new_gap;
      end else if (!ent_vld_r) begin
        // first free entry: every earlier entry is taken and did not match
        ent_vld_nxt  = 1'b1;
        ent_key_nxt  = tok_i.key;
        ent_last_nxt = tok_i.tstamp;
        ent_gap_nxt  = tok_i.tstamp;
        tok_nxt.done = 1'b1;
        tok_nxt.best = tok_i.tstamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      ent_vld_r  <= ent_vld_nxt;
      ent_key_r  <= ent_key_nxt;
      ent_last_r <= ent_last_nxt;
      ent_gap_r  <= ent_gap_nxt;
      tok_r      <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: hdl/per_id_min_interval_tracker_unit.sv
// Tracks, per 64-bit client id, the last arrival time and the smallest gap
// between arrivals, for up to ENTRIES ids. Each arrival walks a row of
// ENTRIES cells, one cell per cycle; each cell owns one table entry and does
// one key compare and one 48-bit subtract/compare. New arrivals enter every
// cycle unless the result side stalls, so it sustains one item per cycle;
// each item passes the ENTRIES cell registers and then the result register.
// A stall on the result side freezes the whole row and stalls the input.
// The table is empty after reset; ids are stored in arrival order and never
// freed, and an unknown id with no free entry gives table_full, best gap 0.
module per_id_min_interval_tracker_unit #(
  parameter int unsigned ENTRIES = pimit_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pimit_pkg::KEY_W-1:0]   in_client_id,
  input  logic [pimit_pkg::TIME_W-1:0]  in_arrival_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_was_known,
  output logic                          out_table_full,
  output logic [pimit_pkg::TIME_W-1:0]  out_best_gap
);

  pimit_pkg::tok_t               chain [ENTRIES+1];
  pimit_pkg::tok_t               last_tok;
  logic                          adv;
  logic                          out_valid_r;
  logic                          out_known_r;
  logic                          out_full_r;
  logic [pimit_pkg::TIME_W-1:0]  out_best_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    chain[0].vld    = in_valid;
    chain[0].done   = 1'b0;
    chain[0].known  = 1'b0;
    chain[0].key    = in_client_id;
    chain[0].tstamp = in_arrival_time;
    chain[0].best   = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pimit_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  assign last_tok = chain[ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last_tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_known_r <= last_tok.known;
      out_full_r  <= !last_tok.done;
      out_best_r  <= last_tok.done ? last_tok.best : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_was_known  = out_known_r;
  assign out_table_full = out_full_r;
  assign out_best_gap   = out_best_r;

endmodule

// File: hdl/pimit_checker.sv
module pimit_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_was_known,
  input logic                          out_table_full,
  input logic [pimit_pkg::TIME_W-1:0]  out_best_gap
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_was_known)
      && $stable(out_table_full) && $stable(out_best_gap))
    else $error("stalled result changed");

  a_full_not_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_table_full && out_was_known))
    else $error("dropped item reported as known");

  a_full_zero_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_best_gap == '0)
    else $error("dropped item with nonzero gap");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result row is frozen");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind per_id_min_interval_tracker_unit pimit_checker u_pimit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_was_known  (out_was_known),
  .out_table_full (out_table_full),
  .out_best_gap   (out_best_gap)
);

// File: sim/per_id_min_interval_tracker_unit_test.sv
module per_id_min_interval_tracker_unit_test;

  localparam int TABLE_SIZE = pimit_pkg::ENTRIES_DEF;
  localparam int ITEM_COUNT = 1450;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [pimit_pkg::KEY_W-1:0]  id;
    logic [pimit_pkg::TIME_W-1:0] stamp;
  } arrival_t;

  typedef struct {
    logic                         known;
    logic                         full;
    logic [pimit_pkg::TIME_W-1:0] gap;
  } gap_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pimit_pkg::KEY_W-1:0] in_client_id = '0;
  logic [pimit_pkg::TIME_W-1:0] in_arrival_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_was_known;
  logic out_table_full;
  logic [pimit_pkg::TIME_W-1:0] out_best_gap;

  arrival_t arrivals_q[$];
  gap_report_t reports_q[$];

  // shadow of the id table
  logic slot_used[TABLE_SIZE];
  logic [pimit_pkg::KEY_W-1:0] slot_key[TABLE_SIZE];
  logic [pimit_pkg::TIME_W-1:0] slot_last[TABLE_SIZE];
  logic [pimit_pkg::TIME_W-1:0] slot_gap[TABLE_SIZE];
  int slots_taken = 0;

  int mismatches = 0;
  int results_seen = 0;
  int item_total = ITEM_COUNT;
  logic in_taken = 1'b0;

  int tx_gap = 0;
  logic tx_calm = 1'b0;
  int rx_burst = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic rx_calm = 1'b0;

  per_id_min_interval_tracker_unit #(.ENTRIES(TABLE_SIZE)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_client_id(in_client_id),
    .in_arrival_time(in_arrival_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_was_known(out_was_known),
    .out_table_full(out_table_full),
    .out_best_gap(out_best_gap)
  );

  always #5 clk = ~clk;

  function automatic gap_report_t track_arrival(input logic [pimit_pkg::KEY_W-1:0] id,
                                                input logic [pimit_pkg::TIME_W-1:0] now);
    gap_report_t r;
    int hit;
    logic [pimit_pkg::TIME_W-1:0] gap;
    r.known = 1'b0;
    r.full = 1'b0;
    r.gap = '0;
    hit = -1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == id) hit = i;
    end
    if (hit >= 0) begin
      // time going backwards saturates the gap to zero
      gap = (now >= slot_last[hit]) ? now - slot_last[hit] : '0;
      if (gap < slot_gap[hit]) slot_gap[hit] = gap;
      slot_last[hit] = now;
      r.known = 1'b1;
      r.gap = slot_gap[hit];
    end else if (slots_taken < TABLE_SIZE) begin
      slot_used[slots_taken] = 1'b1;
      slot_key[slots_taken] = id;
      slot_last[slots_taken] = now;
      slot_gap[slots_taken] = now;
      slots_taken++;
      r.gap = now;
    end else begin
      r.full = 1'b1;
    end
    return r;
  endfunction

  // check results, then record the item accepted at this edge
  always @(posedge clk) begin
    gap_report_t seen;
    gap_report_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        seen.known = out_was_known;
        seen.full = out_table_full;
        seen.gap = out_best_gap;
        if (reports_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual known=%0b full=%0b gap=%h",
                   $time, seen.known, seen.full, seen.gap);
          mismatches++;
        end else begin
          want = reports_q.pop_front();
          if (seen.known !== want.known) begin
            $display("%0t: was_known expected %0b actual %0b", $time, want.known, seen.known);
            mismatches++;
          end
          if (seen.full !== want.full) begin
            $display("%0t: table_full expected %0b actual %0b", $time, want.full, seen.full);
            mismatches++;
          end
          if (seen.gap !== want.gap) begin
            $display("%0t: best_gap expected %h actual %h", $time, want.gap, seen.gap);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        reports_q.push_back(track_arrival(in_client_id, in_arrival_time));
      end
    end
  end

  always @(negedge clk) begin
    arrival_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap == 0 && !tx_calm && arrivals_q.size() >= TAIL_ITEMS &&
          $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(1, 8);
      end
      if (tx_gap > 0 || arrivals_q.size() == 0) begin
        in_valid <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end else begin
        nxt = arrivals_q.pop_front();
        in_valid <= 1'b1;
        in_client_id <= nxt.id;
        in_arrival_time <= nxt.stamp;
      end
      if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= 200) begin
      // long hold so the row fills up and the input stalls
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_burst == 0 && !rx_calm && results_seen < item_total - TAIL_ITEMS &&
          $urandom_range(0, 5) == 0) begin
        rx_burst = $urandom_range(1, 8);
      end
      out_stall <= (rx_burst > 0);
      if (rx_burst > 0) rx_burst--;
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
    end
  end

  task automatic queue_arrival(input logic [pimit_pkg::KEY_W-1:0] id,
                               input logic [pimit_pkg::TIME_W-1:0] stamp);
    arrival_t a;
    a.id = id;
    a.stamp = stamp;
    arrivals_q.push_back(a);
  endtask

  initial begin
    logic [pimit_pkg::KEY_W-1:0] pool_id[$];
    logic [pimit_pkg::TIME_W-1:0] pool_time[$];
    logic [63:0] r64;
    logic [pimit_pkg::KEY_W-1:0] id;
    logic [pimit_pkg::TIME_W-1:0] stamp;
    int idx;

    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_last[i] = '0;
      slot_gap[i] = '0;
    end

    // directed: extreme keys and times, gap shrinking, backwards time
    queue_arrival('0, '0);
    queue_arrival('1, '1);
    queue_arrival('0, 48'd5);
    queue_arrival('1, '0);
    queue_arrival(64'h8000_0000_0000_0000, 48'd1000);
    queue_arrival(64'h8000_0000_0000_0000, 48'd1007);
    queue_arrival(64'h8000_0000_0000_0000, 48'd1107);
    queue_arrival(64'h8000_0000_0000_0000, 48'd1107);
    queue_arrival(64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555);
    queue_arrival(64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    queue_arrival(64'hAAAA_AAAA_AAAA_AAAA, 48'hFFFF_FFFF_FFFF);
    queue_arrival(64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAB);
    queue_arrival(64'h0000_0000_0000_0001, 48'h0000_0000_0001);
    queue_arrival(64'h8000_0000_0000_0000, 48'd1000);

    // random: a growing pool of ids, mostly revisited; the table fills and
    // later ids overflow it
    while (arrivals_q.size() < item_total) begin
      if (pool_id.size() == 0 || $urandom_range(0, 99) < 8) begin
        r64 = {$urandom, $urandom};
        if (pool_id.size() != 0 && $urandom_range(0, 3) == 0) begin
          id = pool_id[$urandom_range(0, pool_id.size() - 1)] ^
               (64'h1 << $urandom_range(0, 63));
        end else begin
          id = r64;
        end
        r64 = {$urandom, $urandom};
        stamp = r64[pimit_pkg::TIME_W-1:0];
        pool_id.push_back(id);
        pool_time.push_back(stamp);
      end else begin
        if ($urandom_range(0, 3) != 0 && pool_id.size() > TABLE_SIZE) begin
          idx = $urandom_range(0, TABLE_SIZE - 1);
        end else begin
          idx = $urandom_range(0, pool_id.size() - 1);
        end
        id = pool_id[idx];
        stamp = pool_time[idx];
        case ($urandom_range(0, 9))
          0: stamp = stamp;
          1: stamp = stamp - $urandom_range(1, 1000);
          2: begin
            r64 = {$urandom, $urandom};
            stamp = stamp + r64[pimit_pkg::TIME_W-1:0];
          end
          default: stamp = stamp + $urandom_range(1, 64);
        endcase
        pool_time[idx] = stamp;
      end
      queue_arrival(id, stamp);
    end
    item_total = arrivals_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (arrivals_q.size() != 0 || in_valid) @(negedge clk);
    while (reports_q.size() != 0) @(negedge clk);
    repeat (TABLE_SIZE + 10) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
hdl/pimit_pkg.sv
hdl/pimit_cell.sv
hdl/per_id_min_interval_tracker_unit.sv
hdl/pimit_checker.sv
sim/per_id_min_interval_tracker_unit_test.sv
